### rtl/smir_pkg.sv
// ----------------------------------------------------------------------------
// smir_pkg
// Shared types and codes of the segmented memory with id recycling.
// ----------------------------------------------------------------------------
package smir_pkg;

   localparam int WORD_W = 32;

   typedef logic [2:0] op_type;
   typedef logic [2:0] status_type;

   localparam op_type OP_MAP    = 3'd0;
   localparam op_type OP_UNMAP  = 3'd1;
   localparam op_type OP_READ   = 3'd2;
   localparam op_type OP_WRITE  = 3'd3;
   localparam op_type OP_APPEND = 3'd4;
   localparam op_type OP_LOAD   = 3'd5;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_UNMAPPED  = 3'd1;
   localparam status_type ST_RANGE     = 3'd2;
   localparam status_type ST_NO_ID     = 3'd3;
   localparam status_type ST_TOO_LARGE = 3'd4;

   typedef struct packed {
      op_type              operation;
      logic [5:0]          segment;
      logic [9:0]          index;
      logic [WORD_W-1:0]   word;
      logic [10:0]         length;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_word;
      status_type          status;
   } rsp_type;

endpackage

### rtl/segmented_memory_with_id_recycling_unit.sv
// ----------------------------------------------------------------------------
// segmented_memory_with_id_recycling_unit
// Segmented word memory with map, unmap, read, write, append, load program.
// ----------------------------------------------------------------------------
// After reset the segment table is swept clear with busy high. A command is
// taken when start is high and busy low; its single result appears on
// rsp_data for one cycle with rsp_strobe and cannot be held off.
// Unmap, write, append, unknown codes, load program from segment 0 and all
// error cases finish after the lookup; read adds one word store access; map
// and load program from any other segment are set by the word counter that
// walks the store one word a cycle.
// ----------------------------------------------------------------------------
module segmented_memory_with_id_recycling_unit #(
   parameter int SEGMENTS      = 64,
   parameter int SEGMENT_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smir_pkg::req_type req_data,
   output logic              rsp_strobe,
   output smir_pkg::rsp_type rsp_data
);
   import smir_pkg::*;

   localparam int SEG_W  = $clog2(SEGMENTS);
   localparam int LEN_W  = $clog2(SEGMENT_WORDS + 1);
   localparam int OFF_W  = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
   localparam int ADDR_W = SEG_W + OFF_W;
   localparam int FR_W   = $clog2(SEGMENTS + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOOKUP = 5'b00010,
      S_READ   = 5'b00100,
      S_FILL   = 5'b01000,
      S_COPY   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [FR_W-1:0]   fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              tbl_ready, tbl_mapped;
   logic [LEN_W-1:0]  tbl_length;
   logic [SEG_W-1:0]  tbl_rd_addr, tbl_wr_addr;
   logic              tbl_we, tbl_wr_mapped;
   logic [LEN_W-1:0]  tbl_wr_length;

   logic              fifo_push, fifo_pop, fifo_empty, fifo_full;
   logic [SEG_W-1:0]  fifo_head_id;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [WORD_W-1:0] mem_wd, mem_rd;

   logic [SEG_W-1:0]  req_seg;
   logic              live;

   assign busy    = (state_ff != S_IDLE) || !tbl_ready;
   assign accept  = start && !busy;
   assign req_seg = SEG_W'(req_ff.segment);
   assign live    = (32'(req_ff.segment) < 32'(SEGMENTS)) && tbl_mapped;
   assign tbl_rd_addr = SEG_W'(req_data.segment);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      seg_in        = seg_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      tbl_we        = 1'b0;
      tbl_wr_addr   = req_seg;
      tbl_wr_mapped = 1'b0;
      tbl_wr_length = '0;
      fifo_push     = 1'b0;
      fifo_pop      = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = {req_seg, OFF_W'(req_ff.index)};
      mem_wd        = req_ff.word;
      mem_ra        = {req_seg, OFF_W'(req_ff.index)};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            rsp_in       = '{read_word: '0, status: ST_OK};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            cnt_in       = '0;
            unique case (req_ff.operation) inside
               OP_MAP: begin
                  if (32'(req_ff.length) > 32'(SEGMENT_WORDS)) begin
                     rsp_in.status = ST_TOO_LARGE;
                  end else if (!fifo_empty || fresh_ff < FR_W'(SEGMENTS)) begin
                     if (!fifo_empty) begin
                        fifo_pop = 1'b1;
                        seg_in   = fifo_head_id;
                     end else begin
                        fresh_in = FR_W'(fresh_ff + 1'b1);
                        seg_in   = SEG_W'(fresh_ff);
                     end
                     len_in        = LEN_W'(req_ff.length);
                     tbl_we        = 1'b1;
                     tbl_wr_addr   = seg_in;
                     tbl_wr_mapped = 1'b1;
                     tbl_wr_length = LEN_W'(req_ff.length);
                     rsp_in.read_word = WORD_W'(seg_in);
                     if (req_ff.length != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_FILL;
                     end
                  end else begin
                     rsp_in.status = ST_NO_ID;
                  end
               end

               OP_UNMAP: begin
                  if (!live) begin
                     rsp_in.status = ST_UNMAPPED;
                  end else begin
                     tbl_we    = 1'b1;
                     fifo_push = (req_seg != '0) && !fifo_full;
                  end
               end

               OP_READ, OP_WRITE: begin
                  if (!live) begin
                     rsp_in.status = ST_UNMAPPED;
                  end else if (32'(req_ff.index) >= 32'(tbl_length)) begin
                     rsp_in.status = ST_RANGE;
                  end else if (req_ff.operation == OP_WRITE) begin
                     mem_we = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_READ;
                  end
               end

               OP_APPEND: begin
                  if (!live) begin
                     rsp_in.status = ST_UNMAPPED;
                  end else if (32'(tbl_length) >= 32'(SEGMENT_WORDS)) begin
                     rsp_in.status = ST_TOO_LARGE;
                  end else begin
                     mem_we        = 1'b1;
                     mem_wa        = {req_seg, OFF_W'(tbl_length)};
                     tbl_we        = 1'b1;
                     tbl_wr_mapped = 1'b1;
                     tbl_wr_length = LEN_W'(tbl_length + 1'b1);
                  end
               end

               OP_LOAD: begin
                  if (!live) begin
                     rsp_in.status = ST_UNMAPPED;
                  end else if (req_seg != '0) begin
                     seg_in        = req_seg;
                     len_in        = tbl_length;
                     tbl_we        = 1'b1;
                     tbl_wr_addr   = '0;
                     tbl_wr_mapped = 1'b1;
                     tbl_wr_length = tbl_length;
                     rsp_valid_in  = 1'b0;
                     state_in      = S_COPY;
                  end
               end

               default: begin
               end
            endcase
         end

         S_READ: begin
            rsp_in       = '{read_word: mem_rd, status: ST_OK};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_FILL: begin
            mem_we = 1'b1;
            mem_wa = {seg_ff, OFF_W'(cnt_ff)};
            mem_wd = '0;
            cnt_in = LEN_W'(cnt_ff + 1'b1);
            if (LEN_W'(cnt_ff + 1'b1) == len_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_COPY: begin
            mem_ra = {seg_ff, OFF_W'(cnt_ff)};
            mem_we = (cnt_ff != '0);
            mem_wa = {SEG_W'(0), OFF_W'(cnt_ff - 1'b1)};
            mem_wd = mem_rd;
            cnt_in = LEN_W'(cnt_ff + 1'b1);
            if (cnt_ff == len_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      seg_ff <= seg_in;
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   smir_seg_table #(
      .SEGMENTS (SEGMENTS),
      .LEN_W    (LEN_W)
   ) u_seg_table (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (tbl_rd_addr),
      .rd_mapped (tbl_mapped),
      .rd_length (tbl_length),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_wr_addr),
      .wr_mapped (tbl_wr_mapped),
      .wr_length (tbl_wr_length),
      .ready     (tbl_ready)
   );

   smir_id_fifo #(
      .SEGMENTS (SEGMENTS)
   ) u_id_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .push_id (req_seg),
      .pop     (fifo_pop),
      .head_id (fifo_head_id),
      .empty   (fifo_empty),
      .full    (fifo_full)
   );

   smir_word_mem #(
      .ADDR_W (ADDR_W)
   ) u_word_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

endmodule

### rtl/smir_word_mem.sv
// ----------------------------------------------------------------------------
// smir_word_mem
// Word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smir_word_mem #(
   parameter int ADDR_W = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [smir_pkg::WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [smir_pkg::WORD_W-1:0] rd_data
);
   import smir_pkg::*;

   logic [WORD_W-1:0] mem [2**ADDR_W];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/smir_seg_table.sv
// ----------------------------------------------------------------------------
// smir_seg_table
// Per-segment mapped flag and length, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module smir_seg_table #(
   parameter int SEGMENTS = 64,
   parameter int LEN_W    = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(SEGMENTS)-1:0]   rd_addr,
   output logic                          rd_mapped,
   output logic [LEN_W-1:0]              rd_length,
   input  logic                          wr_en,
   input  logic [$clog2(SEGMENTS)-1:0]   wr_addr,
   input  logic                          wr_mapped,
   input  logic [LEN_W-1:0]              wr_length,
   output logic                          ready
);
   import smir_pkg::*;

   localparam int SEG_W = $clog2(SEGMENTS);

   logic [LEN_W:0]     mem [SEGMENTS];
   logic [LEN_W:0]     rd_q_ff;
   logic               clearing_ff, clearing_in;
   logic [SEG_W-1:0]   clr_addr_ff, clr_addr_in;
   logic               mem_we;
   logic [SEG_W-1:0]   mem_wa;
   logic [LEN_W:0]     mem_wd;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = SEG_W'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == SEG_W'(SEGMENTS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_addr;
         mem_wd = {wr_mapped, wr_length};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_mapped = rd_q_ff[LEN_W];
   assign rd_length = rd_q_ff[LEN_W-1:0];
   assign ready     = !clearing_ff;

endmodule

### rtl/smir_id_fifo.sv
// ----------------------------------------------------------------------------
// smir_id_fifo
// Queue of released segment ids, oldest first.
// ----------------------------------------------------------------------------
module smir_id_fifo #(
   parameter int SEGMENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [$clog2(SEGMENTS)-1:0]   push_id,
   input  logic                          pop,
   output logic [$clog2(SEGMENTS)-1:0]   head_id,
   output logic                          empty,
   output logic                          full
);
   import smir_pkg::*;

   localparam int SEG_W = $clog2(SEGMENTS);
   localparam int CNT_W = $clog2(SEGMENTS + 1);

   logic [SEG_W-1:0] mem [SEGMENTS];
   logic [SEG_W-1:0] head_id_ff;
   logic [SEG_W-1:0] head_ff, head_in;
   logic [SEG_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == SEG_W'(SEGMENTS - 1)) ? '0 : SEG_W'(tail_ff + 1'b1);
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop) begin
         head_in  = (head_ff == SEG_W'(SEGMENTS - 1)) ? '0 : SEG_W'(head_ff + 1'b1);
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_id;
      end
      head_id_ff <= mem[head_ff];
   end

   assign head_id = head_id_ff;
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(SEGMENTS));

endmodule
